// ----- hdl/ece_pkg.sv -----
// ----------------------------------------------------------------------------
// ece_pkg
// shared types and constants of the encoder count extender
// ----------------------------------------------------------------------------
`default_nettype none

package ece_pkg;

  localparam int unsigned AuxChannels = 2;
  localparam int unsigned NumCh       = 2 + AuxChannels;
  localparam int unsigned SmpW        = 8;
  localparam int unsigned PosW        = 16;
  localparam int unsigned RawW        = 32;
  localparam int unsigned ScaleW      = 32;
  localparam int unsigned ShiftW      = 3;
  localparam int unsigned CfgIdxW     = 8;
  localparam int unsigned FracW       = 24;

  // channel slots
  localparam int unsigned ChLeft  = 0;
  localparam int unsigned ChRight = 1;

  localparam logic [ScaleW-1:0] ScaleOne   = ScaleW'(1) << FracW;
  localparam logic [NumCh-1:0]  RevDefault = NumCh'(13);

  typedef enum logic [1:0] {
    OpPrime  = 2'd0,
    OpStep   = 2'd1,
    OpUpdate = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegRightScale  = 8'd0,
    RegReverseMask = 8'd1,
    RegLeftShift   = 8'd2,
    RegRightShift  = 8'd3,
    RegAux0Shift   = 8'd4,
    RegAux1Shift   = 8'd5
  } reg_idx_e;

  typedef struct packed {
    logic [ScaleW-1:0]            right_scale;
    logic [NumCh-1:0]             reverse_mask;
    logic [NumCh-1:0][ShiftW-1:0] shift;
  } cfg_t;

  // pipeline moves, one bit per register bank
  typedef struct packed {
    logic in_adv;     // item leaves the input register, channel state updates
    logic mid_load;   // update word enters the tracking register
    logic prod_load;  // correction product is registered
    logic out_load;   // result register takes a word
  } pipe_ctrl_t;

  typedef struct packed {
    logic [NumCh-1:0][PosW-1:0] delta;
    logic [NumCh-1:0][PosW-1:0] pos;
    logic [RawW-1:0]            raw;
  } upd_t;

  typedef struct packed {
    logic [NumCh-1:0][PosW-1:0] delta;
    logic [NumCh-1:0][PosW-1:0] pos;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/ece_cfg.sv -----
// ----------------------------------------------------------------------------
// ece_cfg
// configuration register bank, written through a valid/ready port
// ----------------------------------------------------------------------------
`default_nettype none

module ece_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [ece_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ece_pkg::ScaleW-1:0]   cfg_data_i,
  output ece_pkg::cfg_t                     cfg_o
);

  ece_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ece_pkg::RegRightScale:  cfg_d.right_scale  = cfg_data_i;
        ece_pkg::RegReverseMask: cfg_d.reverse_mask = cfg_data_i[ece_pkg::NumCh-1:0];
        ece_pkg::RegLeftShift:   cfg_d.shift[0]     = cfg_data_i[ece_pkg::ShiftW-1:0];
        ece_pkg::RegRightShift:  cfg_d.shift[1]     = cfg_data_i[ece_pkg::ShiftW-1:0];
        ece_pkg::RegAux0Shift:   cfg_d.shift[2]     = cfg_data_i[ece_pkg::ShiftW-1:0];
        ece_pkg::RegAux1Shift:   cfg_d.shift[3]     = cfg_data_i[ece_pkg::ShiftW-1:0];
        default:                 cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.right_scale  <= ece_pkg::ScaleOne;
      cfg_q.reverse_mask <= ece_pkg::RevDefault;
      cfg_q.shift        <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- hdl/ece_track.sv -----
// ----------------------------------------------------------------------------
// ece_track
// per channel sample tracking, step totals and position update
// ----------------------------------------------------------------------------
`default_nettype none

module ece_track (
  input  wire logic                                            clk_i,
  input  wire logic                                            rst_ni,
  input  wire ece_pkg::pipe_ctrl_t                             ctrl_i,
  input  wire ece_pkg::cfg_t                                   cfg_i,
  input  wire logic [1:0]                                      op_i,
  input  wire logic [ece_pkg::NumCh-1:0][ece_pkg::SmpW-1:0]    sample_i,
  output ece_pkg::upd_t                                        mid_o
);

  localparam int unsigned NumCh = ece_pkg::NumCh;
  localparam int unsigned SmpW  = ece_pkg::SmpW;
  localparam int unsigned PosW  = ece_pkg::PosW;
  localparam int unsigned RawW  = ece_pkg::RawW;

  logic [NumCh-1:0][SmpW-1:0] prev_smp_q, prev_smp_d;
  logic [NumCh-1:0][PosW-1:0] step_q, step_d;
  logic [NumCh-1:0][PosW-1:0] prev_step_q, prev_step_d;
  logic [NumCh-1:0][PosW-1:0] pos_q, pos_d;
  logic [RawW-1:0]            raw_q, raw_d;

  logic [NumCh-1:0][SmpW-1:0] smp_diff;
  logic [NumCh-1:0][PosW-1:0] step_new;
  logic [NumCh-1:0][PosW-1:0] masked;
  logic [NumCh-1:0][PosW-1:0] diff;
  logic [NumCh-1:0][PosW-1:0] chan_delta;
  logic [NumCh-1:0][PosW-1:0] pos_new;
  logic [RawW-1:0]            raw_new;
  ece_pkg::upd_t              mid_q;

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      smp_diff[c]   = sample_i[c] - prev_smp_q[c];
      step_new[c]   = step_q[c] + {{(PosW-SmpW){smp_diff[c][SmpW-1]}}, smp_diff[c]};
      masked[c]     = step_new[c] & (PosW'('1) << cfg_i.shift[c]);
      diff[c]       = cfg_i.reverse_mask[c] ? (prev_step_q[c] - masked[c])
                                            : (masked[c] - prev_step_q[c]);
      chan_delta[c] = $signed(diff[c]) >>> cfg_i.shift[c];
      pos_new[c]    = pos_q[c] + chan_delta[c];
    end
    raw_new = raw_q + {{(RawW-PosW){chan_delta[ece_pkg::ChRight][PosW-1]}},
                       chan_delta[ece_pkg::ChRight]};
  end

  always_comb begin
    prev_smp_d  = prev_smp_q;
    step_d      = step_q;
    prev_step_d = prev_step_q;
    pos_d       = pos_q;
    raw_d       = raw_q;
    case (op_i)
      ece_pkg::OpPrime: prev_smp_d = sample_i;
      ece_pkg::OpStep: begin
        prev_smp_d = sample_i;
        step_d     = step_new;
      end
      ece_pkg::OpUpdate: begin
        prev_smp_d  = sample_i;
        step_d      = step_new;
        prev_step_d = masked;
        pos_d       = pos_new;
        raw_d       = raw_new;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_smp_q  <= '0;
      step_q      <= '0;
      prev_step_q <= '0;
      pos_q       <= '0;
      raw_q       <= '0;
    end else if (ctrl_i.in_adv) begin
      prev_smp_q  <= prev_smp_d;
      step_q      <= step_d;
      prev_step_q <= prev_step_d;
      pos_q       <= pos_d;
      raw_q       <= raw_d;
    end
  end

  // update word towards the correction stage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mid_load) begin
      mid_q.delta <= chan_delta;
      mid_q.pos   <= pos_new;
      mid_q.raw   <= raw_new;
    end
  end

  assign mid_o = mid_q;

endmodule

`default_nettype wire

// ----- hdl/ece_correct.sv -----
// ----------------------------------------------------------------------------
// ece_correct
// right channel scale correction and result register
// ----------------------------------------------------------------------------
`default_nettype none

module ece_correct (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ece_pkg::pipe_ctrl_t ctrl_i,
  input  wire ece_pkg::cfg_t       cfg_i,
  input  wire ece_pkg::upd_t       mid_i,
  output ece_pkg::res_t            res_o
);

  localparam int unsigned PosW   = ece_pkg::PosW;
  localparam int unsigned RawW   = ece_pkg::RawW;
  localparam int unsigned ScaleW = ece_pkg::ScaleW;
  localparam int unsigned FracW  = ece_pkg::FracW;
  localparam int unsigned ProdW  = RawW + ScaleW + 1;

  logic signed [ProdW-1:0] prod;
  logic [PosW-1:0]         right_pos;

  ece_pkg::res_t   prod_q, prod_d;
  ece_pkg::res_t   res_q, res_d;
  logic [PosW-1:0] rpos_q;
  logic [PosW-1:0] right_delta;

  // signed sum times unsigned f8.24 factor, rounded half up
  assign prod      = $signed(mid_i.raw) * $signed({1'b0, cfg_i.right_scale});
  assign right_pos = prod[FracW+PosW-1:FracW] + PosW'(prod[FracW-1]);

  always_comb begin
    prod_d.delta                 = mid_i.delta;
    prod_d.pos                   = mid_i.pos;
    prod_d.pos[ece_pkg::ChRight] = right_pos;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prod_load) begin
      prod_q <= prod_d;
    end
  end

  assign right_delta = prod_q.pos[ece_pkg::ChRight] - rpos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpos_q <= '0;
    end else if (ctrl_i.out_load) begin
      rpos_q <= prod_q.pos[ece_pkg::ChRight];
    end
  end

  always_comb begin
    res_d                         = prod_q;
    res_d.delta[ece_pkg::ChRight] = right_delta;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ----- hdl/encoder_count_extender.sv -----
// ----------------------------------------------------------------------------
// encoder_count_extender
// extends four wrapping 8-bit encoder counters into 16-bit positions
// ----------------------------------------------------------------------------
// The block takes one word per clock on the input channel while in_stall_o is
// low and, for every update word, presents one result word after it has passed
// the input register, channel tracking register, correction product register
// and result register. Prime and step words change only the channel state
// and produce no result. Sustained rate is one word per cycle when the output
// side does not stall; the channel state (step totals, positions, right raw
// sum) is updated in the same cycle a word leaves the input register, and the
// right position comes from a single 32 by 33 bit multiply in its own stage.
// Stall propagates from the result register back to the input within the
// same cycle, so a full pipeline holds all four words. Configuration is
// written through its own port, always ready, and must only be written when
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_count_extender (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration write port
  input  wire logic                               cfg_valid_i,
  output wire logic                               cfg_ready_o,
  input  wire logic [ece_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [ece_pkg::ScaleW-1:0]         cfg_data_i,
  // input channel
  input  wire logic                               in_valid_i,
  output wire logic                               in_stall_o,
  input  wire logic [1:0]                         operation_i,
  input  wire logic [ece_pkg::SmpW-1:0]           left_sample_i,
  input  wire logic [ece_pkg::SmpW-1:0]           right_sample_i,
  input  wire logic [ece_pkg::SmpW-1:0]           aux0_sample_i,
  input  wire logic [ece_pkg::SmpW-1:0]           aux1_sample_i,
  // result channel
  output wire logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output wire logic signed [ece_pkg::PosW-1:0]    left_delta_o,
  output wire logic signed [ece_pkg::PosW-1:0]    right_delta_o,
  output wire logic signed [ece_pkg::PosW-1:0]    aux0_delta_o,
  output wire logic signed [ece_pkg::PosW-1:0]    aux1_delta_o,
  output wire logic [ece_pkg::PosW-1:0]           left_position_o,
  output wire logic [ece_pkg::PosW-1:0]           right_position_o,
  output wire logic [ece_pkg::PosW-1:0]           aux0_position_o,
  output wire logic [ece_pkg::PosW-1:0]           aux1_position_o
);

  localparam int unsigned NumCh = ece_pkg::NumCh;
  localparam int unsigned SmpW  = ece_pkg::SmpW;

  ece_pkg::cfg_t      cfg;
  ece_pkg::pipe_ctrl_t ctrl;
  ece_pkg::upd_t      mid;
  ece_pkg::res_t      res;

  // input register
  logic                       in_vld_q;
  logic [1:0]                 op_q;
  logic [NumCh-1:0][SmpW-1:0] smp_q;

  // stage valids
  logic mid_vld_q, prod_vld_q, out_vld_q;

  // ready chain, from the result register back towards the input
  logic out_rdy, prod_rdy, mid_rdy, in_rdy;
  logic is_update;

  assign out_rdy  = !out_vld_q  || !out_stall_i;
  assign prod_rdy = !prod_vld_q || out_rdy;
  assign mid_rdy  = !mid_vld_q  || prod_rdy;
  assign in_rdy   = !in_vld_q   || mid_rdy;

  assign is_update = (op_q == ece_pkg::OpUpdate);

  assign ctrl.in_adv    = in_vld_q && mid_rdy;
  assign ctrl.mid_load  = ctrl.in_adv && is_update;
  assign ctrl.prod_load = mid_vld_q && prod_rdy;
  assign ctrl.out_load  = prod_vld_q && out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      mid_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (in_rdy)   in_vld_q   <= in_valid_i;
      if (mid_rdy)  mid_vld_q  <= ctrl.mid_load;
      if (prod_rdy) prod_vld_q <= mid_vld_q;
      if (out_rdy)  out_vld_q  <= prod_vld_q;
    end
  end

  // input word payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_rdy) begin
      op_q     <= operation_i;
      smp_q[0] <= left_sample_i;
      smp_q[1] <= right_sample_i;
      smp_q[2] <= aux0_sample_i;
      smp_q[3] <= aux1_sample_i;
    end
  end

  ece_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ece_track u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .cfg_i    (cfg),
    .op_i     (op_q),
    .sample_i (smp_q),
    .mid_o    (mid)
  );

  ece_correct u_correct (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .cfg_i  (cfg),
    .mid_i  (mid),
    .res_o  (res)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !in_rdy;
  assign out_valid_o = out_vld_q;

  assign left_delta_o     = res.delta[0];
  assign right_delta_o    = res.delta[1];
  assign aux0_delta_o     = res.delta[2];
  assign aux1_delta_o     = res.delta[3];
  assign left_position_o  = res.pos[0];
  assign right_position_o = res.pos[1];
  assign aux0_position_o  = res.pos[2];
  assign aux1_position_o  = res.pos[3];

endmodule

`default_nettype wire

// ----- hdl/ece_checker.sv -----
// ----------------------------------------------------------------------------
// ece_checker
// port level checks of the encoder count extender
// ----------------------------------------------------------------------------
`default_nettype none

module ece_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic [1:0]                 operation_i,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [ece_pkg::PosW-1:0]   left_delta_o,
  input wire logic [ece_pkg::PosW-1:0]   right_delta_o,
  input wire logic [ece_pkg::PosW-1:0]   aux0_delta_o,
  input wire logic [ece_pkg::PosW-1:0]   aux1_delta_o,
  input wire logic [ece_pkg::PosW-1:0]   left_position_o,
  input wire logic [ece_pkg::PosW-1:0]   right_position_o,
  input wire logic [ece_pkg::PosW-1:0]   aux0_position_o,
  input wire logic [ece_pkg::PosW-1:0]   aux1_position_o
);

  localparam int unsigned PosW = ece_pkg::PosW;

  logic acc_upd;
  logic out_acc;
  logic [PosW-1:0] l_q, r_q, a0_q, a1_q;

  assign acc_upd = in_valid_i && !in_stall_o && (operation_i == ece_pkg::OpUpdate);
  assign out_acc = out_valid_o && !out_stall_i;

  // positions of the last delivered word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_q  <= '0;
      r_q  <= '0;
      a0_q <= '0;
      a1_q <= '0;
    end else if (out_acc) begin
      l_q  <= left_position_o;
      r_q  <= right_position_o;
      a0_q <= aux0_position_o;
      a1_q <= aux1_position_o;
    end
  end

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_position_o)
      && $stable(right_position_o) && $stable(right_delta_o))
    else $error("stalled result word changed");

  // an accepted update word reaches the output while the output side does not stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_upd ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("update word did not reach the output in time");

  // every position is the previous one plus the delta
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_position_o == PosW'(l_q + left_delta_o))
      && (right_position_o == PosW'(r_q + right_delta_o))
      && (aux0_position_o == PosW'(a0_q + aux0_delta_o))
      && (aux1_position_o == PosW'(a1_q + aux1_delta_o)))
    else $error("position does not follow previous position plus delta");

endmodule

bind encoder_count_extender ece_checker u_checker (.*);

`default_nettype wire

// ----- tb/ece_result_checker.sv -----
// ----------------------------------------------------------------------------
// ece_result_checker
// tracks the encoder channel state beside the block, predicts every update
// word and compares the result channel against it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ece_result_checker
  import ece_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [ScaleW-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [1:0]               operation_i,
  input  logic [SmpW-1:0]          left_sample_i,
  input  logic [SmpW-1:0]          right_sample_i,
  input  logic [SmpW-1:0]          aux0_sample_i,
  input  logic [SmpW-1:0]          aux1_sample_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [PosW-1:0]   left_delta_i,
  input  logic signed [PosW-1:0]   right_delta_i,
  input  logic signed [PosW-1:0]   aux0_delta_i,
  input  logic signed [PosW-1:0]   aux1_delta_i,
  input  logic [PosW-1:0]          left_position_i,
  input  logic [PosW-1:0]          right_position_i,
  input  logic [PosW-1:0]          aux0_position_i,
  input  logic [PosW-1:0]          aux1_position_i,
  output int unsigned              mismatches_o,
  output int unsigned              outstanding_o
);

  localparam int unsigned ChAux0 = 2;
  localparam int unsigned ChAux1 = 3;
  localparam logic signed [65:0] RoundHalf = 66'sd1 <<< (FracW - 1);

  cfg_t                       cfg;
  logic [NumCh-1:0][SmpW-1:0] last_sample;
  logic [NumCh-1:0][PosW-1:0] step_sum;
  logic [NumCh-1:0][PosW-1:0] last_step_sum;
  logic [NumCh-1:0][PosW-1:0] position;
  logic [RawW-1:0]            right_raw;
  res_t                       update_q[$];
  res_t                       seen;
  res_t                       want;
  res_t                       fresh;
  int unsigned                mismatch_count = 0;

  function automatic string channel_name(int unsigned c);
    case (c)
      ChLeft:  return "left";
      ChRight: return "right";
      ChAux0:  return "aux0";
      default: return "aux1";
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic apply_write(input logic [CfgIdxW-1:0] idx, input logic [ScaleW-1:0] data);
    case (idx)
      RegRightScale:  cfg.right_scale = data;
      RegReverseMask: cfg.reverse_mask = data[NumCh-1:0];
      RegLeftShift:   cfg.shift[ChLeft] = data[ShiftW-1:0];
      RegRightShift:  cfg.shift[ChRight] = data[ShiftW-1:0];
      RegAux0Shift:   cfg.shift[ChAux0] = data[ShiftW-1:0];
      RegAux1Shift:   cfg.shift[ChAux1] = data[ShiftW-1:0];
      default: ;
    endcase
  endtask

  // signed 8-bit sample change into the 16-bit step sums
  task automatic take_step(input logic [NumCh-1:0][SmpW-1:0] smp);
    logic [SmpW-1:0] change;
    for (int c = 0; c < NumCh; c++) begin
      change = smp[c] - last_sample[c];
      step_sum[c] = step_sum[c] + {{(PosW-SmpW){change[SmpW-1]}}, change};
      last_sample[c] = smp[c];
    end
  endtask

  task automatic take_update(output res_t r);
    logic [PosW-1:0]   masked;
    logic [PosW-1:0]   diff;
    logic [PosW-1:0]   moved;
    logic [PosW-1:0]   new_pos;
    logic signed [65:0] product;
    for (int c = 0; c < NumCh; c++) begin
      masked = step_sum[c] & (16'hffff << cfg.shift[c]);
      diff = cfg.reverse_mask[c] ? last_step_sum[c] - masked : masked - last_step_sum[c];
      last_step_sum[c] = masked;
      moved = $signed(diff) >>> cfg.shift[c];
      if (c == ChRight) begin
        // raw sum times unsigned f8.24 scale, round half up, floor
        right_raw = right_raw + {{(RawW-PosW){moved[PosW-1]}}, moved};
        product = $signed(right_raw) * $signed({1'b0, cfg.right_scale}) + RoundHalf;
        new_pos = product[FracW+PosW-1:FracW];
        r.delta[c] = new_pos - position[c];
        position[c] = new_pos;
      end else begin
        r.delta[c] = moved;
        position[c] = position[c] + moved;
      end
      r.pos[c] = position[c];
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.right_scale = ScaleOne;
      cfg.reverse_mask = RevDefault;
      cfg.shift = '0;
      last_sample = '0;
      step_sum = '0;
      last_step_sum = '0;
      position = '0;
      right_raw = '0;
      update_q.delete();
      outstanding_o <= 0;
      mismatches_o <= mismatch_count;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        apply_write(cfg_index_i, cfg_data_i);
      end
      // result side first, a word accepted this edge cannot be out yet
      if (out_valid_i && !out_stall_i) begin
        seen.delta = {aux1_delta_i, aux0_delta_i, right_delta_i, left_delta_i};
        seen.pos = {aux1_position_i, aux0_position_i, right_position_i, left_position_i};
        if (update_q.size() == 0) begin
          report_mismatch("result word with no update pending");
        end else begin
          want = update_q.pop_front();
          for (int c = 0; c < NumCh; c++) begin
            if (seen.delta[c] !== want.delta[c])
              report_mismatch($sformatf("%s delta got %0d want %0d", channel_name(c),
                              $signed(seen.delta[c]), $signed(want.delta[c])));
            if (seen.pos[c] !== want.pos[c])
              report_mismatch($sformatf("%s position got %0d want %0d", channel_name(c),
                              seen.pos[c], want.pos[c]));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (operation_i)
          OpPrime:  last_sample = {aux1_sample_i, aux0_sample_i, right_sample_i, left_sample_i};
          OpStep:   take_step({aux1_sample_i, aux0_sample_i, right_sample_i, left_sample_i});
          OpUpdate: begin
            take_step({aux1_sample_i, aux0_sample_i, right_sample_i, left_sample_i});
            take_update(fresh);
            update_q.push_back(fresh);
          end
          default: ;
        endcase
      end
      outstanding_o <= update_q.size();
      mismatches_o <= mismatch_count;
    end
  end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives the encoder count extender with directed and random sample words
// over several register settings and idling patterns; the checker beside the
// block predicts and compares every update result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ece_pkg::*;

  localparam int unsigned ClockLimit     = 200000;
  localparam int unsigned DrainCycles    = 8;     // pipeline is four deep
  localparam int unsigned RandomPhases   = 8;
  localparam int unsigned WordsPerPhase  = 212;
  localparam int unsigned JitterSpan     = 27;
  localparam logic [CfgIdxW-1:0] FirstUnusedReg = 8'd6;
  localparam logic [1:0]         OpIgnored      = 2'd3;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // configuration port
  logic               cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ScaleW-1:0]  cfg_data  = '0;
  wire                cfg_ready;

  // input channel, sample word packed left in slot zero
  logic                       in_valid  = 1'b0;
  logic [1:0]                 operation = OpPrime;
  logic [NumCh-1:0][SmpW-1:0] smp_word  = '0;
  wire                        in_stall;

  // result channel
  logic                   out_stall = 1'b0;
  wire                    out_valid;
  wire signed [PosW-1:0]  left_delta, right_delta, aux0_delta, aux1_delta;
  wire [PosW-1:0]         left_position, right_position, aux0_position, aux1_position;

  // idling pattern of the current phase, percent of cycles
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned mismatches;
  int unsigned outstanding;

  // drift direction per channel, kept over the whole run so totals wrap
  logic [NumCh-1:0] heading;

  encoder_count_extender uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .operation_i      (operation),
    .left_sample_i    (smp_word[ChLeft]),
    .right_sample_i   (smp_word[ChRight]),
    .aux0_sample_i    (smp_word[2]),
    .aux1_sample_i    (smp_word[3]),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .left_delta_o     (left_delta),
    .right_delta_o    (right_delta),
    .aux0_delta_o     (aux0_delta),
    .aux1_delta_o     (aux1_delta),
    .left_position_o  (left_position),
    .right_position_o (right_position),
    .aux0_position_o  (aux0_position),
    .aux1_position_o  (aux1_position)
  );

  ece_result_checker result_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .operation_i      (operation),
    .left_sample_i    (smp_word[ChLeft]),
    .right_sample_i   (smp_word[ChRight]),
    .aux0_sample_i    (smp_word[2]),
    .aux1_sample_i    (smp_word[3]),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .left_delta_i     (left_delta),
    .right_delta_i    (right_delta),
    .aux0_delta_i     (aux0_delta),
    .aux1_delta_i     (aux1_delta),
    .left_position_i  (left_position),
    .right_position_i (right_position),
    .aux0_position_i  (aux0_position),
    .aux1_position_i  (aux1_position),
    .mismatches_o     (mismatches),
    .outstanding_o    (outstanding)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver stall, redrawn every cycle
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == ClockLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [NumCh-1:0][SmpW-1:0] counts(input logic [SmpW-1:0] l, r, a0, a1);
    return {a1, a0, r, l};
  endfunction

  // all tasks start and end just after a rising edge
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ScaleW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_word(input logic [1:0] op, input logic [NumCh-1:0][SmpW-1:0] smp);
    // sender gap before the word
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    operation <= op;
    smp_word  <= smp;
    do @(posedge clk_i); while (in_stall);
  endtask

  // wait until every update result is back, then let prime and step words drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // mostly drifting encoder counts: prime once, then steps and updates with
  // small wrapping changes, some jumps, stray primes and ignored words
  task automatic run_phase(input int unsigned words);
    logic [NumCh-1:0][SmpW-1:0] smp;
    int                         lean [NumCh];
    int                         move;
    int unsigned                roll;
    int unsigned                sent;
    smp = smp_word;
    for (int c = 0; c < NumCh; c++) begin
      lean[c] = int'($urandom_range(0, 100));
      if (!heading[c]) lean[c] = -lean[c];
    end
    send_word(OpPrime, smp);
    sent = 1;
    while (sent < words) begin
      roll = $urandom_range(99);
      for (int c = 0; c < NumCh; c++) begin
        if ($urandom_range(9) == 0 || roll < 4) begin
          smp[c] = SmpW'($urandom);
        end else begin
          move = lean[c] + int'($urandom_range(0, 2 * JitterSpan)) - int'(JitterSpan);
          smp[c] = smp[c] + SmpW'(move);
        end
      end
      if (roll < 4) begin
        send_word(OpPrime, smp);
        sent++;
      end else if (roll < 8) begin
        send_word(OpIgnored, smp);
      end else if (roll < 50) begin
        send_word(OpStep, smp);
        sent++;
      end else begin
        send_word(OpUpdate, smp);
        sent++;
      end
    end
  endtask

  initial begin
    logic [ScaleW-1:0] scale;
    logic [ScaleW-1:0] mask;
    logic [ScaleW-1:0] shift [NumCh];
    heading = NumCh'($urandom);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words under the reset settings, no idling
    send_word(OpUpdate,  counts(8'h00, 8'h00, 8'h00, 8'h00));  // update straight from reset
    send_word(OpPrime,   counts(8'hff, 8'h00, 8'h80, 8'h7f));
    send_word(OpStep,    counts(8'h7e, 8'h7f, 8'hff, 8'hfe));  // largest forward change
    send_word(OpUpdate,  counts(8'h7e, 8'h7f, 8'hff, 8'hfe));  // update with no change
    send_word(OpStep,    counts(8'hfe, 8'hff, 8'h7f, 8'h7e));  // largest backward change
    send_word(OpUpdate,  counts(8'h00, 8'hff, 8'h80, 8'h7f));
    send_word(OpIgnored, counts(8'hff, 8'hff, 8'hff, 8'hff));  // ignored operation
    send_word(OpUpdate,  counts(8'hff, 8'hff, 8'hff, 8'hff));
    send_word(OpPrime,   counts(8'h55, 8'haa, 8'h55, 8'haa));
    send_word(OpUpdate,  counts(8'haa, 8'h55, 8'haa, 8'h55));
    send_word(OpStep,    counts(8'h2a, 8'hd5, 8'h2a, 8'hd5));
    send_word(OpStep,    counts(8'haa, 8'h55, 8'haa, 8'h55));
    send_word(OpUpdate,  counts(8'h2a, 8'hd5, 8'h2a, 8'hd5));
    wait_idle();

    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      if (phase == 0) begin
        // lowest settings
        scale = '0;
        mask  = '0;
        for (int c = 0; c < NumCh; c++) shift[c] = '0;
      end else if (phase == 1) begin
        // highest settings
        scale = '1;
        mask  = NumCh'('1);
        for (int c = 0; c < NumCh; c++) shift[c] = ShiftW'('1);
      end else begin
        // oversized data on purpose, only the low bits count
        case ($urandom_range(2))
          0:       scale = ScaleOne;
          1:       scale = ScaleOne + ScaleW'($urandom_range(0, 1 << 22)) - (ScaleW'(1) << 21);
          default: scale = $urandom;
        endcase
        mask = $urandom;
        for (int c = 0; c < NumCh; c++) shift[c] = $urandom;
      end
      write_reg(RegRightScale,  scale);
      write_reg(RegReverseMask, mask);
      write_reg(RegLeftShift,   shift[ChLeft]);
      write_reg(RegRightShift,  shift[ChRight]);
      write_reg(RegAux0Shift,   shift[2]);
      write_reg(RegAux1Shift,   shift[3]);
      // a write to an unused index must change nothing
      write_reg(FirstUnusedReg + CfgIdxW'($urandom_range(0, 249)), $urandom);

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      run_phase(WordsPerPhase);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- encoder_count_extender.f -----
hdl/ece_pkg.sv
hdl/ece_cfg.sv
hdl/ece_track.sv
hdl/ece_correct.sv
hdl/encoder_count_extender.sv
hdl/ece_checker.sv
tb/ece_result_checker.sv
tb/testbench.sv
